// ===== hw/rtl/hsrc_pkg.sv =====
package hsrc_pkg;

    // Field widths of the request and response channels
    localparam int unsigned REQ_TYPE_W = 1;
    localparam int unsigned ROW_W      = 10;
    localparam int unsigned WIDX_W     = 4;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned CLUSTER_W  = 11;

    // Row length limit set by the 16-word output framing
    localparam int unsigned OUT_WORD_LIMIT = 16;
    localparam int unsigned CLUSTER_LIMIT  = OUT_WORD_LIMIT * WORD_W;

    // Default matrix size
    localparam int unsigned MAX_CLUSTERS_DEF = 1024;

    // Request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_LOAD    = 1'b0;
    localparam logic [REQ_TYPE_W-1:0] REQ_COMPUTE = 1'b1;

endpackage

// ===== hw/rtl/hsrc_if.sv =====
// Request channel: one matrix word load or one row compute
interface hsrc_req_if
    import hsrc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [ROW_W-1:0]      row;
    logic [WIDX_W-1:0]     word_index;
    logic [WORD_W-1:0]     word_data;

    modport source (output valid, req_type, row, word_index, word_data, input ready);
    modport sink   (input valid, req_type, row, word_index, word_data, output ready);
endinterface

// Response channel: the hearable row words of a compute request
interface hsrc_rsp_if
    import hsrc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [WIDX_W-1:0]    out_word_index;
    logic [WORD_W-1:0]    out_data;
    logic                 last;
    logic [CLUSTER_W-1:0] hearable_count;
    logic                 bad_bit;

    modport source (output valid, out_word_index, out_data, last, hearable_count, bad_bit,
                    input ready);
    modport sink   (input valid, out_word_index, out_data, last, hearable_count, bad_bit,
                    output ready);
endinterface

// ===== hw/rtl/hearable_set_row_closure.sv =====
// Channel   Dir  Handshake     Payload
// req       in   valid/ready   req_type, row, word_index, word_data
// rsp       out  valid/ready   out_word_index, out_data, last, hearable_count, bad_bit
// cfg       in   cfg_we        cfg_wdata (num_clusters)
//
// Every source row of a compute costs nw reads on the single matrix memory port,
// nw = ceil(n/64). One request is worked at a time.
// Reset clears control state and the accumulator; the matrix memory is not cleared.
// A stalled response holds in the output register; a new request is taken meanwhile.
module hearable_set_row_closure
    import hsrc_pkg::*;
#(
    parameter int unsigned MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CLUSTER_W-1:0] cfg_wdata,
    hsrc_req_if.sink             req,
    hsrc_rsp_if.source           rsp
);

    // Usable matrix geometry
    localparam int unsigned CAP       = (MAX_CLUSTERS < CLUSTER_LIMIT) ? MAX_CLUSTERS
                                                                       : CLUSTER_LIMIT;
    localparam int unsigned CAP_WORDS = (CAP + WORD_W - 1) / WORD_W;
    localparam int unsigned RB        = $clog2(CAP);
    localparam int unsigned WB        = (CAP_WORDS > 1) ? $clog2(CAP_WORDS) : 1;
    localparam int unsigned AB        = RB + WB;
    localparam int unsigned DEPTH     = 1 << AB;
    localparam int unsigned BB        = $clog2(WORD_W);
    localparam int unsigned PB        = BB + 1;

    localparam logic [CLUSTER_W-1:0] CAP_N      = CLUSTER_W'(CAP);
    localparam logic [WIDX_W:0]      CAP_WORDS_N = (WIDX_W + 1)'(CAP_WORDS);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_SELW = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_OR   = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    // Valid-bit mask of one row word
    function automatic logic [WORD_W-1:0] word_mask(input logic [WB-1:0] w,
                                                    input logic [WB-1:0] w_last,
                                                    input logic [BB-1:0] rem);
        logic [WORD_W-1:0] m;
        if (w != w_last || rem == '0)
            m = '1;
        else
            m = (WORD_W'(1) << rem) - WORD_W'(1);
        return m;
    endfunction

    // Lowest set bit position
    function automatic logic [BB-1:0] low_bit(input logic [WORD_W-1:0] v);
        logic [BB-1:0] b;
        b = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
                b = BB'(i);
        end
        return b;
    endfunction

    logic [CLUSTER_W-1:0] n_reg;
    logic [2:0]           state_reg, state_next;
    logic [WB-1:0]        k_reg, k_next;
    logic [WB-1:0]        w_reg, w_next;
    logic [RB-1:0]        row_reg, row_next;
    logic [RB-1:0]        src_reg, src_next;
    logic [WORD_W-1:0]    sel_reg, sel_next;
    logic                 bad_reg, bad_next;
    logic [CLUSTER_W-1:0] cnt_reg, cnt_next;
    logic                 tag_valid_reg, tag_valid_next;
    logic                 tag_init_reg, tag_init_next;
    logic [WB-1:0]        tag_k_reg, tag_k_next;
    logic [WORD_W-1:0]    rdata_reg;
    logic [WORD_W-1:0]    acc_reg [CAP_WORDS];

    logic                 out_valid_reg, out_valid_next;
    logic [WIDX_W-1:0]    out_widx_reg, out_widx_next;
    logic [WORD_W-1:0]    out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;
    logic [CLUSTER_W-1:0] out_cnt_reg, out_cnt_next;
    logic                 out_bad_reg, out_bad_next;

    logic [WORD_W-1:0]    pvs_mem [DEPTH];
    logic                 mem_we;
    logic [AB-1:0]        mem_waddr;
    logic [AB-1:0]        mem_raddr;

    logic [CLUSTER_W-1:0] n_eff;
    logic [WB-1:0]        w_last;
    logic [WORD_W-1:0]    sel_mask;
    logic [WB-1:0]        acc_idx;
    logic [WORD_W-1:0]    acc_rd;
    logic [PB-1:0]        word_pop;
    logic [WB+BB-1:0]     bit_idx;
    logic                 out_free;

    // Cluster count clamped to 1 .. CAP
    always_comb
    begin
        if (n_reg == '0)
            n_eff = CLUSTER_W'(1);
        else if (n_reg > CAP_N)
            n_eff = CAP_N;
        else
            n_eff = n_reg;
    end

    assign w_last    = WB'((n_eff - CLUSTER_W'(1)) >> BB);
    assign sel_mask  = word_mask(w_reg, w_last, n_eff[BB-1:0]);
    assign acc_idx   = (state_reg == S_EMIT) ? w_reg : tag_k_reg;
    assign acc_rd    = acc_reg[acc_idx];
    assign word_pop  = PB'($countones(acc_rd & word_mask(w_reg, w_last, n_eff[BB-1:0])));
    assign bit_idx   = {w_reg, low_bit(sel_reg)};
    assign out_free  = !out_valid_reg || rsp.ready;
    assign mem_waddr = {req.row[RB-1:0], req.word_index[WB-1:0]};

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.out_word_index = out_widx_reg;
    assign rsp.out_data       = out_data_reg;
    assign rsp.last           = out_last_reg;
    assign rsp.hearable_count = out_cnt_reg;
    assign rsp.bad_bit        = out_bad_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        w_next         = w_reg;
        row_next       = row_reg;
        src_next       = src_reg;
        sel_next       = sel_reg;
        bad_next       = bad_reg;
        cnt_next       = cnt_reg;
        tag_valid_next = 1'b0;
        tag_init_next  = tag_init_reg;
        tag_k_next     = tag_k_reg;
        mem_we         = 1'b0;
        mem_raddr      = {row_reg, k_reg};
        out_valid_next = out_valid_reg && !rsp.ready;
        out_widx_next  = out_widx_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_cnt_next   = out_cnt_reg;
        out_bad_next   = out_bad_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.req_type == REQ_LOAD)
                    begin
                        mem_we = ({1'b0, req.row} < CAP_N) &&
                                 ({1'b0, req.word_index} < CAP_WORDS_N);
                    end
                    else if ({1'b0, req.row} < n_eff)
                    begin
                        row_next   = req.row[RB-1:0];
                        k_next     = '0;
                        w_next     = '0;
                        bad_next   = 1'b0;
                        cnt_next   = '0;
                        state_next = S_INIT;
                    end
                end
            end

            // Seed the accumulator with row r
            S_INIT:
            begin
                mem_raddr      = {row_reg, k_reg};
                tag_valid_next = 1'b1;
                tag_init_next  = 1'b1;
                tag_k_next     = k_reg;
                if (k_reg == w_last)
                    state_next = S_SEL;
                else
                    k_next = k_reg + WB'(1);
            end

            // Fetch selector word w of row r
            S_SEL:
            begin
                mem_raddr  = {row_reg, w_reg};
                state_next = S_SELW;
            end

            S_SELW:
            begin
                sel_next   = rdata_reg & sel_mask;
                bad_next   = bad_reg || ((rdata_reg & ~sel_mask) != '0);
                state_next = S_SCAN;
            end

            // Pick the next set selector bit
            S_SCAN:
            begin
                if (sel_reg == '0)
                begin
                    if (w_reg == w_last)
                    begin
                        w_next     = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        w_next     = w_reg + WB'(1);
                        state_next = S_SEL;
                    end
                end
                else
                begin
                    src_next   = bit_idx[RB-1:0];
                    sel_next   = sel_reg & (sel_reg - WORD_W'(1));
                    k_next     = '0;
                    state_next = S_OR;
                end
            end

            // OR source row into the accumulator
            S_OR:
            begin
                mem_raddr      = {src_reg, k_reg};
                tag_valid_next = 1'b1;
                tag_init_next  = 1'b0;
                tag_k_next     = k_reg;
                if (k_reg == w_last)
                    state_next = S_SCAN;
                else
                    k_next = k_reg + WB'(1);
            end

            // Stream the row out through the output register
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_widx_next  = WIDX_W'(w_reg);
                    out_data_next  = acc_rd;
                    out_last_next  = (w_reg == w_last);
                    out_cnt_next   = (w_reg == w_last) ? cnt_reg + CLUSTER_W'(word_pop) : '0;
                    out_bad_next   = bad_reg;
                    cnt_next       = cnt_reg + CLUSTER_W'(word_pop);
                    if (w_reg == w_last)
                        state_next = S_IDLE;
                    else
                        w_next = w_reg + WB'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= CLUSTER_W'(1);
            state_reg     <= S_IDLE;
            tag_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                n_reg <= cfg_wdata;
            state_reg     <= state_next;
            tag_valid_reg <= tag_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        w_reg        <= w_next;
        row_reg      <= row_next;
        src_reg      <= src_next;
        sel_reg      <= sel_next;
        bad_reg      <= bad_next;
        cnt_reg      <= cnt_next;
        tag_init_reg <= tag_init_next;
        tag_k_reg    <= tag_k_next;
        out_widx_reg <= out_widx_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_cnt_reg  <= out_cnt_next;
        out_bad_reg  <= out_bad_next;
    end

    // Accumulator update from the registered read data and its registered tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAP_WORDS; i++)
                acc_reg[i] <= '0;
        end
        else if (tag_valid_reg)
        begin
            if (tag_init_reg)
                acc_reg[tag_k_reg] <= rdata_reg;
            else
                acc_reg[tag_k_reg] <= acc_rd | rdata_reg;
        end
    end

    // Matrix memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            pvs_mem[mem_waddr] <= req.word_data;
        rdata_reg <= pvs_mem[mem_raddr];
    end

endmodule

// ===== hw/rtl/hsrc_checker.sv =====
module hsrc_checker
    import hsrc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic [REQ_TYPE_W-1:0] req_type,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic                  rsp_last,
    input logic [WIDX_W-1:0]     rsp_word_index,
    input logic [WORD_W-1:0]     rsp_data
);

    // A load completes in its own cycle
    a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_LOAD |=> req_ready)
        else $error("load did not return to ready");

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_word_index))
        else $error("stalled response changed");

    // A new row starts at word zero
    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && rsp_last |=> !rsp_valid || rsp_word_index == '0)
        else $error("row did not start at word zero");

    // Words of a row come in order
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp_last
            |=> !rsp_valid || rsp_word_index == $past(rsp_word_index) + WIDX_W'(1))
        else $error("row word out of order");

endmodule

bind hearable_set_row_closure hsrc_checker u_hsrc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_type       (req.req_type),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_last       (rsp.last),
    .rsp_word_index (rsp.out_word_index),
    .rsp_data       (rsp.out_data)
);
